### hdl/spq_pkg.sv
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic signed [DATA_W-1:0] TOP_EMPTY = 32'sh7FFF_FFFF;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } spq_cmd_t;

endpackage

### hdl/spq_cell.sv
// one storage cell of the sorted row, largest value in cell 0
module spq_cell
  import spq_pkg::*;
(
  input  logic                     clk_i,
  input  spq_cmd_t                 cmd_i,
  input  logic                     occ_i,
  input  logic                     above_keep_i,
  input  logic signed [DATA_W-1:0] above_val_i,
  input  logic signed [DATA_W-1:0] below_val_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     keep_o
);

  logic signed [DATA_W-1:0] val_q, val_d;

  // entry stays in place on a push only when it is strictly greater
  assign keep_o = occ_i && (val_q > cmd_i.value);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    priority if (cmd_i.push) begin
      if (keep_o) begin
        val_d = val_q;
      end else if (above_keep_i) begin
        val_d = cmd_i.value;
      end else begin
        val_d = above_val_i;
      end
    end else if (cmd_i.pop) begin
      val_d = below_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### hdl/sorted_priority_queue.sv
// sorted priority queue: a row of compare-and-shift cells, largest value in the first cell
//
// input channel: in_valid_i with kind_i and value_i, transferred when in_stall_o is low.
//   kind push inserts value_i, pop removes the largest entry, peek (and the unused
//   code) changes nothing.
// output channel: one result per input transfer on out_valid_o with status_o,
//   top_value_o, has_top_o and count_o, transferred when out_stall_i is low.
// every cell compares the pushed value with its own entry and shifts toward its
//   neighbor in the same cycle.
// the result is registered and shown in the cycle after the input transfer.
// the queue takes one operation per cycle while the output is taken every cycle.
// a full queue answers a push with overflow, an empty one answers pop or peek
//   with underflow; top_value_o reads 2147483647 when empty.
// reset clears the entry count and the output valid; entries are not cleared.
// while a result waits under out_stall_i the input is stalled and nothing changes.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [DATA_W-1:0]   top_value_o,
  output logic                       has_top_o,
  output logic [COUNT_W-1:0]         count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntZero = '0;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic signed [DATA_W-1:0] top_q, top_d;
  logic                     has_top_q;
  logic [COUNT_W-1:0]       count_q;

  logic accept;
  logic is_push, is_pop, empty, full;
  spq_cmd_t cmd;

  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic                     cell_keep [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign empty      = (cnt_q == CntZero);
  assign full       = (cnt_q == CntFull);
  assign is_push    = (kind_i == KIND_PUSH);
  assign is_pop     = (kind_i == KIND_POP);

  assign cmd.push  = accept && is_push && !full;
  assign cmd.pop   = accept && is_pop && !empty;
  assign cmd.value = value_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic                     above_keep;
    logic signed [DATA_W-1:0] above_val;
    logic signed [DATA_W-1:0] below_val;

    if (i == 0) begin : g_first
      // first cell: nothing above, the pushed value enters here when it is largest
      assign above_keep = 1'b1;
      assign above_val  = value_i;
    end else begin : g_mid
      assign above_keep = cell_keep[i-1];
      assign above_val  = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below_val = value_i;
    end else begin : g_below
      assign below_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (cnt_q > Idx),
      .above_keep_i (above_keep),
      .above_val_i  (above_val),
      .below_val_i  (below_val),
      .val_o        (cell_val[i]),
      .keep_o       (cell_keep[i])
    );
  end

  // count, status and top after the operation
  always_comb begin
    cnt_d    = cnt_q;
    status_d = STATUS_OK;
    top_d    = empty ? TOP_EMPTY : cell_val[0];
    priority if (is_push) begin
      if (full) begin
        status_d = STATUS_OVERFLOW;
      end else begin
        cnt_d = cnt_q + CntOne;
        top_d = cell_keep[0] ? cell_val[0] : value_i;
      end
    end else if (is_pop) begin
      if (empty) begin
        status_d = STATUS_UNDERFLOW;
      end else begin
        cnt_d = cnt_q - CntOne;
        top_d = (cnt_q == CntOne) ? TOP_EMPTY : cell_val[1];
      end
    end else begin
      if (empty) begin
        status_d = STATUS_UNDERFLOW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      top_q     <= top_d;
      has_top_q <= (cnt_d != CntZero);
      count_q   <= COUNT_W'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign top_value_o = top_q;
  assign has_top_o   = has_top_q;
  assign count_o     = count_q;

endmodule
